FILE: hw/rtl/skdt_pkg.sv
// Shared types and codes for the sorted key/data table.
`default_nettype none
package skdt_pkg;

	localparam logic [3:0] MODE_INSERT    = 4'd0;
	localparam logic [3:0] MODE_FIND_KEY  = 4'd1;
	localparam logic [3:0] MODE_FIND_POS  = 4'd2;
	localparam logic [3:0] MODE_DEL_KEY   = 4'd3;
	localparam logic [3:0] MODE_DEL_POS   = 4'd4;
	localparam logic [3:0] MODE_DEL_DATA  = 4'd5;
	localparam logic [3:0] MODE_POP       = 4'd6;
	localparam logic [3:0] MODE_COUNT     = 4'd7;
	localparam logic [3:0] MODE_FREE_KEY  = 4'd8;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic key_eq;
		logic key_gt;
		logic data_eq;
	} cmp_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/skdt_store.sv
// Key and data entry memories: one write port, one registered read port.
`default_nettype none
module skdt_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int KW    = 32,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [KW-1:0] wr_key,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [KW-1:0] rd_key,
	output logic      [DW-1:0] rd_data
);

	logic [KW-1:0] key_mem [DEPTH];
	logic [DW-1:0] data_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]  <= wr_key;
			data_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key  <= key_mem[rd_addr];
			rd_data <= data_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/skdt_cmp.sv
// Shared compare unit: stored entry against the reference key and data word.
`default_nettype none
module skdt_cmp #(
	parameter int KW = 32,
	parameter int DW = 32
) (
	input  wire logic [KW-1:0] ent_key,
	input  wire logic [DW-1:0] ent_data,
	input  wire logic [KW-1:0] ref_key,
	input  wire logic [DW-1:0] ref_data,
	output skdt_pkg::cmp_res_t res
);

	import skdt_pkg::*;

	always_comb begin
		res.key_eq  = (ent_key == ref_key);
		res.key_gt  = (ent_key > ref_key);
		res.data_eq = (ent_data == ref_data);
	end

endmodule
`default_nettype wire

FILE: hw/rtl/sorted_key_data_table_unit.sv
// Sorted key/data table: command sequencer, result register and handshake.
// Find and delete by key or data walk the entries from index 0; insert and delete shift
// the entries behind the position by one place; the free-key walk rescans when its key wraps.
// One transaction at a time: in_stall is high whenever the sequencer is not idle.
// Reset: entry count and control cleared at once; entry memories are not cleared.
`default_nettype none
module sorted_key_data_table_unit #(
	parameter int CAPACITY   = 32,
	parameter int KEY_WIDTH  = 32,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  mode,
	input  wire logic [31:0] key,
	input  wire logic [31:0] data_in,
	input  wire logic [4:0]  position,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [1:0]  status,
	output logic      [31:0] data_out,
	output logic      [4:0]  insert_position,
	output logic      [5:0]  entry_count,
	output logic      [31:0] free_key
);

	import skdt_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 5) ? CW : 5;
	localparam int KW = KEY_WIDTH;
	localparam int DW = DATA_WIDTH;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DEC, ST_SCAN, ST_RDP, ST_RDW, ST_SHDN, ST_SHUP, ST_FIN
	} state_t;

	typedef enum logic [1:0] {K_GT, K_KEQ, K_DEQ, K_FREE} kind_t;

	state_t        state_q;
	kind_t         kind_q;
	logic [3:0]    mode_q;
	logic [KW-1:0] key_q;
	logic [DW-1:0] data_q;
	logic [4:0]    pos_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] p_q;
	logic [CW-1:0] iss_q;
	logic [CW-1:0] inc_q;
	logic [KW-1:0] cand_q;
	logic          vld_s1;
	logic [CW-1:0] idx_s1;
	logic [1:0]    res_status_q;
	logic [DW-1:0] res_data_q;
	logic [CW-1:0] res_ipos_q;
	logic [KW-1:0] res_free_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [KW-1:0] rd_key;
	logic [DW-1:0] rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [KW-1:0] wr_key;
	logic [DW-1:0] wr_data;
	logic          issue_up;
	logic          issue_dn;
	logic [CW-1:0] iss_dec;
	logic [CW-1:0] idx_dec;
	logic [CW-1:0] idx_inc;
	logic          hit_eq;
	cmp_res_t      cr;

	skdt_store #(.DEPTH(CAPACITY), .AW(AW), .KW(KW), .DW(DW)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_data (rd_data)
	);

	skdt_cmp #(.KW(KW), .DW(DW)) u_cmp (
		.ent_key  (rd_key),
		.ent_data (rd_data),
		.ref_key  ((kind_q == K_FREE) ? cand_q : key_q),
		.ref_data (data_q),
		.res      (cr)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign hit_eq   = (kind_q == K_DEQ) ? cr.data_eq : cr.key_eq;
	assign issue_up = (iss_q < cnt_q);
	assign issue_dn = (iss_q > p_q);
	assign iss_dec  = iss_q - CW'(1);
	assign idx_dec  = idx_s1 - CW'(1);
	assign idx_inc  = idx_s1 + CW'(1);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = iss_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_dec[AW-1:0];
		wr_key  = rd_key;
		wr_data = rd_data;
		case (state_q)
			ST_SCAN, ST_SHDN: begin
				rd_en = issue_up;
				if (state_q == ST_SHDN) begin
					wr_en = vld_s1;
				end
			end
			ST_RDP: begin
				rd_en   = 1'b1;
				rd_addr = p_q[AW-1:0];
			end
			ST_SHUP: begin
				rd_en   = issue_dn;
				rd_addr = iss_dec[AW-1:0];
				if (vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = idx_inc[AW-1:0];
				end else if (!issue_dn) begin
					wr_en   = 1'b1;
					wr_addr = p_q[AW-1:0];
					wr_key  = key_q;
					wr_data = data_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			kind_q          <= K_GT;
			mode_q          <= '0;
			key_q           <= '0;
			data_q          <= '0;
			pos_q           <= '0;
			cnt_q           <= '0;
			p_q             <= '0;
			iss_q           <= '0;
			inc_q           <= '0;
			cand_q          <= '0;
			vld_s1          <= 1'b0;
			idx_s1          <= '0;
			res_status_q    <= STATUS_MISS;
			res_data_q      <= '0;
			res_ipos_q      <= '0;
			res_free_q      <= '0;
			out_valid       <= 1'b0;
			status          <= '0;
			data_out        <= '0;
			insert_position <= '0;
			entry_count     <= '0;
			free_key        <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_FIN) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q  <= mode;
						key_q   <= KW'(key);
						data_q  <= DW'(data_in);
						pos_q   <= position;
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					res_status_q <= STATUS_MISS;
					res_data_q   <= '0;
					res_ipos_q   <= '0;
					res_free_q   <= '0;
					iss_q        <= '0;
					vld_s1       <= 1'b0;
					cand_q       <= key_q;
					inc_q        <= '0;
					state_q      <= ST_FIN;
					case (mode_q)
						MODE_INSERT: begin
							if (cnt_q == CW'(CAPACITY)) begin
								res_status_q <= STATUS_FULL;
							end else begin
								kind_q  <= K_GT;
								state_q <= ST_SCAN;
							end
						end
						MODE_FIND_KEY, MODE_DEL_KEY: begin
							kind_q  <= K_KEQ;
							state_q <= ST_SCAN;
						end
						MODE_DEL_DATA: begin
							kind_q  <= K_DEQ;
							state_q <= ST_SCAN;
						end
						MODE_FIND_POS, MODE_DEL_POS: begin
							if (PW'(pos_q) < PW'(cnt_q)) begin
								p_q     <= CW'(pos_q);
								state_q <= ST_RDP;
							end
						end
						MODE_POP: begin
							if (cnt_q != '0) begin
								p_q     <= '0;
								state_q <= ST_RDP;
							end
						end
						MODE_COUNT: begin
							res_status_q <= STATUS_OK;
						end
						MODE_FREE_KEY: begin
							kind_q  <= K_FREE;
							state_q <= ST_SCAN;
						end
						default: begin
						end
					endcase
				end
				ST_SCAN: begin
					if (issue_up) begin
						iss_q <= iss_q + CW'(1);
					end
					vld_s1 <= issue_up;
					idx_s1 <= iss_q;
					if (vld_s1) begin
						case (kind_q)
							K_GT: begin
								if (cr.key_gt) begin
									p_q     <= idx_s1;
									iss_q   <= cnt_q;
									vld_s1  <= 1'b0;
									state_q <= ST_SHUP;
								end
							end
							K_KEQ, K_DEQ: begin
								if (hit_eq) begin
									res_data_q <= rd_data;
									p_q        <= idx_s1;
									if (mode_q == MODE_FIND_KEY) begin
										res_status_q <= STATUS_OK;
										state_q      <= ST_FIN;
									end else begin
										iss_q   <= idx_inc;
										vld_s1  <= 1'b0;
										state_q <= ST_SHDN;
									end
								end
							end
							default: begin
								if (cr.key_eq) begin
									if (inc_q == cnt_q) begin
										res_free_q <= key_q;
										state_q    <= ST_FIN;
									end else begin
										cand_q <= cand_q + KW'(1);
										inc_q  <= inc_q + CW'(1);
										if (&cand_q) begin
											iss_q  <= '0;
											vld_s1 <= 1'b0;
										end
									end
								end else if (cr.key_gt) begin
									res_free_q   <= cand_q;
									res_status_q <= STATUS_OK;
									state_q      <= ST_FIN;
								end
							end
						endcase
					end else if (!issue_up) begin
						case (kind_q)
							K_GT: begin
								p_q     <= cnt_q;
								iss_q   <= cnt_q;
								state_q <= ST_SHUP;
							end
							K_FREE: begin
								res_free_q   <= cand_q;
								res_status_q <= STATUS_OK;
								state_q      <= ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_RDP: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					res_data_q <= rd_data;
					if (mode_q == MODE_FIND_POS) begin
						res_status_q <= STATUS_OK;
						state_q      <= ST_FIN;
					end else begin
						iss_q   <= p_q + CW'(1);
						vld_s1  <= 1'b0;
						state_q <= ST_SHDN;
					end
				end
				ST_SHDN: begin
					if (issue_up) begin
						iss_q <= iss_q + CW'(1);
					end
					vld_s1 <= issue_up;
					idx_s1 <= iss_q;
					if (!vld_s1 && !issue_up) begin
						cnt_q        <= cnt_q - CW'(1);
						res_status_q <= STATUS_OK;
						state_q      <= ST_FIN;
					end
				end
				ST_SHUP: begin
					if (issue_dn) begin
						iss_q <= iss_dec;
					end
					vld_s1 <= issue_dn;
					idx_s1 <= iss_dec;
					if (!vld_s1 && !issue_dn) begin
						cnt_q        <= cnt_q + CW'(1);
						res_status_q <= STATUS_OK;
						res_ipos_q   <= p_q;
						state_q      <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid || !out_stall) begin
						out_valid       <= 1'b1;
						status          <= res_status_q;
						data_out        <= 32'(res_data_q);
						insert_position <= 5'(res_ipos_q);
						entry_count     <= 6'(cnt_q);
						free_key        <= 32'(res_free_q);
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
